[hdl/lpcc_pkg.sv]
// Package for the lidar point camera colorizer.
// Holds register reset values, register indexes, command codes, default maximum image size and datapath widths.
// No dependencies.
`default_nettype none
package lpcc_pkg;

  localparam int MAX_COLS_DEF = 2048;
  localparam int MAX_ROWS_DEF = 2048;

  localparam int FOCAL_W = 20;
  localparam int SIZE_W  = 12;
  localparam int CFG_W   = 20;
  localparam int PIX_W   = 24;
  localparam int COORD_W = 32;
  localparam int PADDR_W = 11;
  localparam int NUM_W   = 54;

  localparam logic [FOCAL_W-1:0] FOCAL_X_RST = 20'd195258;
  localparam logic [FOCAL_W-1:0] FOCAL_Y_RST = 20'd195258;
  localparam logic [SIZE_W-1:0]  COLS_RST    = 12'd1280;
  localparam logic [SIZE_W-1:0]  ROWS_RST    = 12'd1440;

  typedef enum logic [1:0] {
    REG_FOCAL_X = 2'd0,
    REG_FOCAL_Y = 2'd1,
    REG_COLS    = 2'd2,
    REG_ROWS    = 2'd3
  } reg_index_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_POINT = 1'b1
  } command_t;

endpackage
`default_nettype wire

[hdl/lidar_point_camera_colorizer_top.sv]
// Top level of the lidar point camera colorizer: projection pipeline and image memory.
// Depends on lpcc_pkg.
//
//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  input    | in_valid, in_ready, command, pixel_*, point_*  | in
//  output   | out_valid, out_ready, out_x/y/z, color, hit    | out
//  config   | cfg_we, cfg_index, cfg_data                    | in
//
// One transaction enters per cycle unless the output stalls; a point result passes the product,
// numerator, overflow, divider and address stages, the restoring divider giving one quotient bit per stage.
// Pixel writes travel the same pipeline and reach the single-port image memory at the
// stage where points read it, so all accesses keep their order. The memory is not
// cleared by reset. A stalled output holds each stage until it is taken; empty
// stages still fill.
`default_nettype none
module lidar_point_camera_colorizer_top #(
  parameter int MAX_COLS = lpcc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lpcc_pkg::MAX_ROWS_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    cfg_we,
  input  wire  [1:0]                             cfg_index,
  input  wire  [lpcc_pkg::CFG_W-1:0]             cfg_data,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire                                    command,
  input  wire  [lpcc_pkg::PADDR_W-1:0]           pixel_col,
  input  wire  [lpcc_pkg::PADDR_W-1:0]           pixel_row,
  input  wire  [lpcc_pkg::PIX_W-1:0]             pixel_word,
  input  wire  signed [lpcc_pkg::COORD_W-1:0]    point_x,
  input  wire  signed [lpcc_pkg::COORD_W-1:0]    point_y,
  input  wire  signed [lpcc_pkg::COORD_W-1:0]    point_z,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic signed [lpcc_pkg::COORD_W-1:0]    out_x,
  output logic signed [lpcc_pkg::COORD_W-1:0]    out_y,
  output logic signed [lpcc_pkg::COORD_W-1:0]    out_z,
  output logic [lpcc_pkg::PIX_W-1:0]             color,
  output logic                                   hit
);
  import lpcc_pkg::*;

  localparam int QCW   = $clog2(MAX_COLS);
  localparam int QRW   = $clog2(MAX_ROWS);
  localparam int QW    = (QCW > QRW) ? QCW : QRW;
  localparam int DIVW  = (NUM_W > 40 + QW) ? NUM_W : 40 + QW;
  localparam int CMPW  = ((QW > SIZE_W) ? QW : SIZE_W) + 1;
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NS    = QW + 4;

  typedef struct packed {
    logic                      valid;
    logic                      cmd;
    logic [PADDR_W-1:0]        pcol;
    logic [PADDR_W-1:0]        prow;
    logic [PIX_W-1:0]          pword;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      xpos;
    logic [49:0]               pcx;
    logic signed [52:0]        pyf;
    logic [49:0]               prx;
    logic signed [52:0]        pzf;
    logic                      negc;
    logic                      negr;
    logic                      ovfc;
    logic                      ovfr;
    logic [DIVW-1:0]           remc;
    logic [DIVW-1:0]           remr;
    logic [DIVW-1:0]           den;
    logic [QW-1:0]             qc;
    logic [QW-1:0]             qr;
    logic                      hit;
    logic [AW-1:0]             addr;
  } stage_t;

  logic [FOCAL_W-1:0] focal_x;
  logic [FOCAL_W-1:0] focal_y;
  logic [SIZE_W-1:0]  image_cols;
  logic [SIZE_W-1:0]  image_rows;

  stage_t     stg      [NS];
  stage_t     stg_next [NS];
  stage_t     in_stage;
  logic       load     [NS+1];
  logic [PIX_W-1:0] rdata;
  logic [PIX_W-1:0] img [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x    <= FOCAL_X_RST;
      focal_y    <= FOCAL_Y_RST;
      image_cols <= COLS_RST;
      image_rows <= ROWS_RST;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_FOCAL_X: focal_x <= cfg_data;
        REG_FOCAL_Y: focal_y <= cfg_data;
        REG_COLS:    image_cols <= cfg_data[SIZE_W-1:0];
        REG_ROWS:    image_rows <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_stage       = '0;
    in_stage.valid = in_valid;
    in_stage.cmd   = command;
    in_stage.pcol  = pixel_col;
    in_stage.prow  = pixel_row;
    in_stage.pword = pixel_word;
    in_stage.x     = point_x;
    in_stage.y     = point_y;
    in_stage.z     = point_z;
    in_stage.xpos  = !point_x[COORD_W-1] && (point_x != '0);
    in_stage.pcx   = 50'({image_cols, 7'b0}) * 50'(point_x[COORD_W-2:0]);
    in_stage.prx   = 50'({image_rows, 7'b0}) * 50'(point_x[COORD_W-2:0]);
    in_stage.pyf   = 53'(point_y) * $signed({1'b0, focal_x});
    in_stage.pzf   = 53'(point_z) * $signed({1'b0, focal_y});
  end

  assign load[NS] = !out_valid || out_ready;
  assign in_ready = load[0];

  genvar g;
  for (g = 0; g < NS; g++) begin : g_stage
    assign load[g] = !stg[g].valid || load[g+1];

    if (g == 0) begin : g_mul
      assign stg_next[g] = in_stage;
    end else if (g == 1) begin : g_num
      logic signed [NUM_W-1:0] ncol;
      logic signed [NUM_W-1:0] nrow;
      always_comb begin
        ncol = $signed({4'b0, stg[g-1].pcx}) - NUM_W'(stg[g-1].pyf);
        nrow = $signed({4'b0, stg[g-1].prx}) - NUM_W'(stg[g-1].pzf);
        stg_next[g]      = stg[g-1];
        stg_next[g].negc = ncol[NUM_W-1];
        stg_next[g].negr = nrow[NUM_W-1];
        stg_next[g].remc = DIVW'(ncol[NUM_W-1] ? (~ncol + 1'b1) : ncol);
        stg_next[g].remr = DIVW'(nrow[NUM_W-1] ? (~nrow + 1'b1) : nrow);
        stg_next[g].den  = DIVW'({stg[g-1].x[COORD_W-2:0], 8'b0});
      end
    end else if (g == 2) begin : g_ovf
      logic [DIVW-1:0] lim;
      always_comb begin
        lim = stg[g-1].den << QW;
        stg_next[g]      = stg[g-1];
        stg_next[g].ovfc = stg[g-1].remc >= lim;
        stg_next[g].ovfr = stg[g-1].remr >= lim;
        stg_next[g].qc   = '0;
        stg_next[g].qr   = '0;
      end
    end else if (g < NS - 1) begin : g_div
      localparam int B = QW - (g - 2);
      logic [DIVW-1:0] sub;
      always_comb begin
        sub = stg[g-1].den << B;
        stg_next[g] = stg[g-1];
        if (stg[g-1].remc >= sub) begin
          stg_next[g].remc  = stg[g-1].remc - sub;
          stg_next[g].qc[B] = 1'b1;
        end
        if (stg[g-1].remr >= sub) begin
          stg_next[g].remr  = stg[g-1].remr - sub;
          stg_next[g].qr[B] = 1'b1;
        end
      end
    end else begin : g_addr
      logic col_ok;
      logic row_ok;
      logic wr_ok;
      always_comb begin
        if (stg[g-1].negc) begin
          col_ok = !stg[g-1].ovfc && (stg[g-1].qc == '0) && (image_cols != '0);
        end else begin
          col_ok = !stg[g-1].ovfc && (CMPW'(stg[g-1].qc) < CMPW'(image_cols))
                   && (CMPW'(stg[g-1].qc) < CMPW'(MAX_COLS));
        end
        if (stg[g-1].negr) begin
          row_ok = !stg[g-1].ovfr && (stg[g-1].qr == '0) && (image_rows != '0);
        end else begin
          row_ok = !stg[g-1].ovfr && (CMPW'(stg[g-1].qr) < CMPW'(image_rows))
                   && (CMPW'(stg[g-1].qr) < CMPW'(MAX_ROWS));
        end
        wr_ok = (CMPW'(stg[g-1].pcol) < CMPW'(MAX_COLS))
                && (CMPW'(stg[g-1].prow) < CMPW'(MAX_ROWS));
        stg_next[g] = stg[g-1];
        if (stg[g-1].cmd == CMD_WRITE) begin
          stg_next[g].hit  = wr_ok;
          stg_next[g].addr = AW'(stg[g-1].prow) * AW'(MAX_COLS) + AW'(stg[g-1].pcol);
        end else begin
          stg_next[g].hit  = stg[g-1].xpos && col_ok && row_ok;
          stg_next[g].addr = AW'(stg[g-1].qr) * AW'(MAX_COLS) + AW'(stg[g-1].qc);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[g].valid <= 1'b0;
      end else if (load[g]) begin
        stg[g] <= stg_next[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[NS] && stg[NS-1].valid) begin
      if (stg[NS-1].cmd == CMD_WRITE) begin
        if (stg[NS-1].hit) begin
          img[stg[NS-1].addr] <= stg[NS-1].pword;
        end
      end else begin
        rdata <= img[stg[NS-1].addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load[NS]) begin
      out_valid <= stg[NS-1].valid && (stg[NS-1].cmd == CMD_POINT);
    end
  end

  always_ff @(posedge clk) begin
    if (load[NS] && stg[NS-1].valid && (stg[NS-1].cmd == CMD_POINT)) begin
      out_x <= stg[NS-1].x;
      out_y <= stg[NS-1].y;
      out_z <= stg[NS-1].z;
      hit   <= stg[NS-1].hit;
    end
  end

  assign color = hit ? rdata : '0;

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for lidar_point_camera_colorizer_top: directed table, then random.
// Predicts each point's projection and color from its own copy of the image and registers; typed rows supply their own.
// Depends on lpcc_pkg and the RTL of the colorizer.
`default_nettype none
module tb_top;
  import lpcc_pkg::*;

  localparam int STORE_COLS = 2048;
  localparam int STORE_ROWS = 2048;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    command_t         cmd;
    logic [10:0]      pcol;
    logic [10:0]      prow;
    logic [23:0]      word;
    int               px;
    int               py;
    int               pz;
    bit               typed;
    logic [23:0]      tcolor;
    bit               thit;
  } stim_t;

  typedef struct {
    int          x;
    int          y;
    int          z;
    logic [23:0] color;
    bit          hit;
  } colored_point_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_FOCAL_X;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic command = CMD_WRITE;
  logic [PADDR_W-1:0] pixel_col = '0;
  logic [PADDR_W-1:0] pixel_row = '0;
  logic [PIX_W-1:0] pixel_word = '0;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic signed [COORD_W-1:0] point_z = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [COORD_W-1:0] out_x, out_y, out_z;
  logic [PIX_W-1:0] color;
  logic hit;

  logic [19:0] focal_x_m, focal_y_m;
  logic [11:0] cols_m, rows_m;
  logic [23:0] image_m [int];
  colored_point_t pending_points [$];
  stim_t directed [$];
  int errors = 0;
  bit quiet = 0;

  lidar_point_camera_colorizer_top dut (.*);

  always #10 clk = ~clk;

  initial begin
    #(20 * 400000);
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic bit project_point(input int px, input int py, input int pz,
                                       output int pcol, output int prow);
    longint xx, yy, zz, den, c, r, cw, rw;
    xx = px;
    yy = py;
    zz = pz;
    cw = cols_m;
    rw = rows_m;
    pcol = 0;
    prow = 0;
    if (xx <= 0) return 0;
    den = xx * 256;
    c = (cw * 128 * xx - yy * longint'(focal_x_m)) / den;
    r = -((zz * longint'(focal_y_m) - rw * 128 * xx) / den);
    pcol = int'(c);
    prow = int'(r);
    return c >= 0 && c < cw && c < STORE_COLS && r >= 0 && r < rw && r < STORE_ROWS;
  endfunction

  function automatic void add_row(input stim_t s);
    directed.insert(directed.size(), s);
  endfunction

  task automatic offer(input stim_t s);
    int c, r;
    colored_point_t e;
    bit h;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1;
    command <= s.cmd;
    pixel_col <= s.pcol;
    pixel_row <= s.prow;
    pixel_word <= s.word;
    point_x <= s.px;
    point_y <= s.py;
    point_z <= s.pz;
    do @(posedge clk); while (!in_ready);
    if (s.cmd == CMD_WRITE) begin
      image_m[int'(s.prow) * STORE_COLS + int'(s.pcol)] = s.word;
    end else begin
      h = project_point(s.px, s.py, s.pz, c, r);
      e.x = s.px;
      e.y = s.py;
      e.z = s.pz;
      e.hit = s.typed ? s.thit : h;
      e.color = s.typed ? s.tcolor : (h ? image_m[r * STORE_COLS + c] : 24'd0);
      pending_points.insert(pending_points.size(), e);
    end
  endtask

  // A point that lands on a never-written pixel gets that pixel written first.
  task automatic send(input stim_t s);
    int c, r;
    stim_t w;
    if (s.cmd == CMD_POINT && project_point(s.px, s.py, s.pz, c, r) &&
        !image_m.exists(r * STORE_COLS + c)) begin
      w = '{CMD_WRITE, c[10:0], r[10:0], 24'($urandom), 0, 0, 0, 0, 0, 0};
      offer(w);
    end
    offer(s);
  endtask

  task automatic settle();
    in_valid <= 0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [19:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_FOCAL_X: focal_x_m = val;
      REG_FOCAL_Y: focal_y_m = val;
      REG_COLS:    cols_m = val[11:0];
      default:     rows_m = val[11:0];
    endcase
  endtask

  task automatic configure(input logic [19:0] fx, input logic [19:0] fy,
                           input logic [19:0] nc, input logic [19:0] nr);
    settle();
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_COLS, nc);
    write_reg(REG_ROWS, nr);
    cfg_we <= 0;
  endtask

  function automatic stim_t pixel(input int c, input int r, input logic [23:0] w);
    return '{CMD_WRITE, c[10:0], r[10:0], w, 0, 0, 0, 0, 0, 0};
  endfunction

  function automatic stim_t pt(input int x, input int y, input int z);
    return '{CMD_POINT, 11'd0, 11'd0, 24'd0, x, y, z, 0, 0, 0};
  endfunction

  function automatic stim_t pt_typed(input int x, input int y, input int z,
                                     input logic [23:0] c, input bit h);
    return '{CMD_POINT, 11'd0, 11'd0, 24'd0, x, y, z, 1, c, h};
  endfunction

  function automatic stim_t random_item();
    int x, sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return pixel($urandom_range(0, 2047), $urandom_range(0, 2047), 24'($urandom));
    if (sel < 5) return pt($urandom, $urandom, $urandom);
    x = $urandom_range(32'h1000, 32'h400000);
    return pt(x, int'($urandom_range(0, 2 * x)) - x, int'($urandom_range(0, 2 * x)) - x);
  endfunction

  always @(posedge clk) begin
    colored_point_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        $error("result with nothing expected: x %0d color %h hit %0d", out_x, color, hit);
        errors++;
      end else begin
        e = pending_points.pop_front();
        if (out_x !== e.x) begin
          $error("out_x expected %0d actual %0d", e.x, out_x);
          errors++;
        end
        if (out_y !== e.y) begin
          $error("out_y expected %0d actual %0d", e.y, out_y);
          errors++;
        end
        if (out_z !== e.z) begin
          $error("out_z expected %0d actual %0d", e.z, out_z);
          errors++;
        end
        if (color !== e.color) begin
          $error("color expected %h actual %h", e.color, color);
          errors++;
        end
        if (hit !== e.hit) begin
          $error("hit expected %0d actual %0d", e.hit, hit);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (!rst);
    @(posedge clk);
    out_ready <= 1;
    repeat (300) @(posedge clk);
    out_ready <= 0;
    repeat (400) @(posedge clk);
    forever begin
      out_ready <= 1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!quiet) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  initial begin
    focal_x_m = FOCAL_X_RST;
    focal_y_m = FOCAL_Y_RST;
    cols_m = COLS_RST;
    rows_m = ROWS_RST;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    add_row(pixel(0, 0, 24'hFFFFFF));
    add_row(pixel(2047, 2047, 24'h000000));
    add_row(pixel(640, 720, 24'hA5C3E1));
    add_row(pt_typed(32'h10000, 0, 0, 24'hA5C3E1, 1));
    add_row(pt_typed(0, 0, 0, 24'd0, 0));
    add_row(pt_typed(-1, 5, 5, 24'd0, 0));
    add_row(pt_typed(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 24'd0, 0));
    add_row(pt(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    add_row(pt(32'h7FFFFFFF, 32'h80000000, 32'h80000000));
    add_row(pt(1, 0, 0));
    add_row(pt(1, 32'hFFFFFFFF, 1));
    add_row(pt(32'h10000, 32'h10000, 32'hFFFF0000));
    add_row(pixel(1279, 1439, 24'h5A5A5A));
    add_row(pt(32'h10000, 32'hFFFF2000, 32'hFFFF2000));
    add_row(pt(32'h10000, 32'h20000, 32'h20000));
    foreach (directed[i]) send(directed[i]);

    repeat (250) send(random_item());
    configure(20'hFFFFF, 20'h00000, 20'd2048, 20'd2048);
    repeat (240) send(random_item());
    configure(20'd0, 20'hFFFFF, 20'd4095, 20'd4095);
    repeat (240) send(random_item());
    configure(20'd5000, 20'd5000, 20'd0, 20'd0);
    repeat (110) send(random_item());
    configure(20'd0, 20'd0, 20'd1, 20'd1);
    send(pt_typed(32'h10000, 32'h12345, 32'h777, 24'hFFFFFF, 1));
    repeat (110) send(random_item());
    configure(20'd100000, 20'd300000, 20'd640, 20'd480);
    repeat (240) send(random_item());
    configure(FOCAL_X_RST, FOCAL_Y_RST, 20'(COLS_RST), 20'(ROWS_RST));
    quiet = 1;
    repeat (250) send(random_item());

    settle();
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
